// ===== rtl/pbc_pkg.sv =====
// shared widths, action codes and defaults for the polyline lateral bound check
package pbc_pkg;

    localparam int COORD_W          = 32;
    localparam int PROD_W           = 2 * COORD_W;
    localparam int DIV_STEPS        = COORD_W;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int S_TDATA_W        = 6 * COORD_W;
    localparam int M_TDATA_W        = 40;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

endpackage

// ===== rtl/polyline_lateral_bound_check_unit.sv =====
// clear, append and ignored actions go straight from idle to the result stage; a query reads
// one vertex per cycle through the store read port, then runs up to two end interpolations
// on the shared multiplier and 32-step serial divider
// throughput: one transaction at a time, next accepted once the result is registered
// reset: polyline empty, forbid_left_side = 1, store contents undefined until appended
module polyline_lateral_bound_check_unit
    import pbc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,      // forbid_left_side
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // vertex_s, vertex_l, box_s_min, box_s_max, box_l_min, box_l_max
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,        // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // applies, violates, bound_l, status, zero pad
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_CLIP,
        ST_WALK,
        ST_SUB,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ADD,
        ST_TIGHT_LO,
        ST_TIGHT_HI,
        ST_VIOL,
        ST_DONE
    } state_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    function automatic coord_t pick(input coord_t a, input coord_t b, input logic left);
        if (left)
        begin
            return (a < b) ? a : b;
        end
        return (a > b) ? a : b;
    endfunction

    state_t             state_reg;
    logic               forbid_left_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      last_idx;
    logic [CW-1:0]      k_inc;
    coord_t             bs_lo_reg, bs_hi_reg, bl_lo_reg, bl_hi_reg;
    coord_t             first_s_reg, first_l_reg, last_s_reg, last_l_reg;
    coord_t             s_lo_reg, s_hi_reg;
    coord_t             prev_s_reg, prev_l_reg;
    coord_t             seg_s0_reg [2];
    coord_t             seg_l0_reg [2];
    coord_t             seg_s1_reg [2];
    coord_t             seg_l1_reg [2];
    coord_t             val_reg [2];
    coord_t             acc_reg;
    logic               acc_any_reg;
    logic [1:0]         seg_reg;
    logic [1:0]         found_reg;
    logic               sel_reg;
    logic               neg_reg;
    logic [COORD_W-1:0] mag_reg;
    logic [COORD_W-1:0] ds_reg;
    logic [COORD_W-1:0] dsd_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               res_applies_reg;
    logic               res_violates_reg;
    coord_t             res_ext_reg;
    logic               res_status_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    action_t            in_action;
    coord_t             in_vs, in_vl, in_bs_lo, in_bs_hi, in_bl_lo, in_bl_hi;
    logic               in_fire;
    logic               store_full;
    logic               mem_we;
    logic [AW-1:0]      rd_addr;
    logic [COORD_W-1:0] rd_s_bits, rd_l_bits;
    coord_t             rd_s, rd_l;
    logic               div_start;
    logic               div_done;
    logic [COORD_W-1:0] div_q;

    coord_t             cur_s0, cur_l0, cur_s1, cur_l1, cur_t;
    logic [COORD_W:0]   d_up, d_dn, d_ds, d_dsd;
    coord_t             interp_val;
    logic               out_free;

    assign in_action = action_t'(s_tuser);
    assign in_vs     = s_tdata[COORD_W-1:0];
    assign in_vl     = s_tdata[2*COORD_W-1:COORD_W];
    assign in_bs_lo  = s_tdata[3*COORD_W-1:2*COORD_W];
    assign in_bs_hi  = s_tdata[4*COORD_W-1:3*COORD_W];
    assign in_bl_lo  = s_tdata[5*COORD_W-1:4*COORD_W];
    assign in_bl_hi  = s_tdata[6*COORD_W-1:5*COORD_W];

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign store_full = (cnt_reg >= CW'(MAX_VERTICES));
    assign mem_we     = in_fire && (in_action == ACT_APPEND) && !store_full;
    assign last_idx   = cnt_reg - 1'b1;
    assign k_inc      = k_reg + 1'b1;
    assign div_start  = (state_reg == ST_DIV_GO);
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb
    begin
        unique case (state_reg)
            ST_FIRST: rd_addr = last_idx[AW-1:0];
            ST_WALK:  rd_addr = k_inc[AW-1:0];
            default:  rd_addr = '0;
        endcase
    end

    pbc_vertex_mem #(
        .DEPTH    (MAX_VERTICES)
    ) u_mem (
        .clk      (clk),
        .we       (mem_we),
        .waddr    (cnt_reg[AW-1:0]),
        .wdata_s  (in_vs),
        .wdata_l  (in_vl),
        .raddr    (rd_addr),
        .rdata_s  (rd_s_bits),
        .rdata_l  (rd_l_bits)
    );

    assign rd_s = rd_s_bits;
    assign rd_l = rd_l_bits;

    pbc_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dsd_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // segment operands for the end being interpolated
    assign cur_s0 = seg_s0_reg[sel_reg];
    assign cur_l0 = seg_l0_reg[sel_reg];
    assign cur_s1 = seg_s1_reg[sel_reg];
    assign cur_l1 = seg_l1_reg[sel_reg];
    assign cur_t  = sel_reg ? s_hi_reg : s_lo_reg;
    assign d_up   = {cur_l1[COORD_W-1], cur_l1} - {cur_l0[COORD_W-1], cur_l0};
    assign d_dn   = {cur_l0[COORD_W-1], cur_l0} - {cur_l1[COORD_W-1], cur_l1};
    assign d_ds   = {cur_t[COORD_W-1], cur_t} - {cur_s0[COORD_W-1], cur_s0};
    assign d_dsd  = {cur_s1[COORD_W-1], cur_s1} - {cur_s0[COORD_W-1], cur_s0};
    assign interp_val = neg_reg ? (cur_l0 - coord_t'(div_q)) : (cur_l0 + coord_t'(div_q));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            forbid_left_reg  <= 1'b1;
            cnt_reg          <= '0;
            k_reg            <= '0;
            bs_lo_reg        <= '0;
            bs_hi_reg        <= '0;
            bl_lo_reg        <= '0;
            bl_hi_reg        <= '0;
            first_s_reg      <= '0;
            first_l_reg      <= '0;
            last_s_reg       <= '0;
            last_l_reg       <= '0;
            s_lo_reg         <= '0;
            s_hi_reg         <= '0;
            prev_s_reg       <= '0;
            prev_l_reg       <= '0;
            seg_s0_reg       <= '{default: '0};
            seg_l0_reg       <= '{default: '0};
            seg_s1_reg       <= '{default: '0};
            seg_l1_reg       <= '{default: '0};
            val_reg          <= '{default: '0};
            acc_reg          <= '0;
            acc_any_reg      <= 1'b0;
            seg_reg          <= '0;
            found_reg        <= '0;
            sel_reg          <= 1'b0;
            neg_reg          <= 1'b0;
            mag_reg          <= '0;
            ds_reg           <= '0;
            dsd_reg          <= '0;
            prod_reg         <= '0;
            res_applies_reg  <= 1'b0;
            res_violates_reg <= 1'b0;
            res_ext_reg      <= '0;
            res_status_reg   <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                forbid_left_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        res_applies_reg  <= 1'b0;
                        res_violates_reg <= 1'b0;
                        res_ext_reg      <= '0;
                        bs_lo_reg        <= in_bs_lo;
                        bs_hi_reg        <= in_bs_hi;
                        bl_lo_reg        <= in_bl_lo;
                        bl_hi_reg        <= in_bl_hi;
                        unique case (in_action)
                            ACT_CLEAR:
                            begin
                                cnt_reg        <= '0;
                                res_status_reg <= 1'b0;
                                state_reg      <= ST_DONE;
                            end
                            ACT_APPEND:
                            begin
                                res_status_reg <= store_full;
                                if (!store_full)
                                begin
                                    cnt_reg <= cnt_reg + 1'b1;
                                end
                                state_reg <= ST_DONE;
                            end
                            ACT_QUERY:
                            begin
                                res_status_reg <= 1'b0;
                                state_reg      <= (cnt_reg >= CW'(2)) ? ST_FIRST : ST_DONE;
                            end
                            default:
                            begin
                                res_status_reg <= 1'b0;
                                state_reg      <= ST_DONE;
                            end
                        endcase
                    end
                end

                ST_FIRST:
                begin
                    first_s_reg <= rd_s;
                    first_l_reg <= rd_l;
                    state_reg   <= ST_LAST;
                end

                ST_LAST:
                begin
                    last_s_reg <= rd_s;
                    last_l_reg <= rd_l;
                    s_lo_reg   <= (bs_lo_reg > first_s_reg) ? bs_lo_reg : first_s_reg;
                    s_hi_reg   <= (bs_hi_reg < rd_s) ? bs_hi_reg : rd_s;
                    if (bs_hi_reg < first_s_reg || bs_lo_reg > rd_s)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_CLIP;
                    end
                end

                ST_CLIP:
                begin
                    // ends at or beyond the polyline take the end vertex directly
                    priority if (s_lo_reg <= first_s_reg)
                    begin
                        val_reg[0] <= first_l_reg;
                        seg_reg[0] <= 1'b0;
                    end
                    else if (s_lo_reg >= last_s_reg)
                    begin
                        val_reg[0] <= last_l_reg;
                        seg_reg[0] <= 1'b0;
                    end
                    else
                    begin
                        seg_reg[0] <= 1'b1;
                    end
                    priority if (s_hi_reg <= first_s_reg)
                    begin
                        val_reg[1] <= first_l_reg;
                        seg_reg[1] <= 1'b0;
                    end
                    else if (s_hi_reg >= last_s_reg)
                    begin
                        val_reg[1] <= last_l_reg;
                        seg_reg[1] <= 1'b0;
                    end
                    else
                    begin
                        seg_reg[1] <= 1'b1;
                    end
                    found_reg   <= '0;
                    acc_any_reg <= 1'b0;
                    k_reg       <= '0;
                    state_reg   <= ST_WALK;
                end

                ST_WALK:
                begin
                    if (rd_s > s_lo_reg && rd_s < s_hi_reg)
                    begin
                        acc_reg     <= acc_any_reg ? pick(acc_reg, rd_l, forbid_left_reg) : rd_l;
                        acc_any_reg <= 1'b1;
                    end
                    if (seg_reg[0] && !found_reg[0] && k_reg != '0 && s_lo_reg <= rd_s)
                    begin
                        seg_s0_reg[0] <= prev_s_reg;
                        seg_l0_reg[0] <= prev_l_reg;
                        seg_s1_reg[0] <= rd_s;
                        seg_l1_reg[0] <= rd_l;
                        found_reg[0]  <= 1'b1;
                    end
                    if (seg_reg[1] && !found_reg[1] && k_reg != '0 && s_hi_reg <= rd_s)
                    begin
                        seg_s0_reg[1] <= prev_s_reg;
                        seg_l0_reg[1] <= prev_l_reg;
                        seg_s1_reg[1] <= rd_s;
                        seg_l1_reg[1] <= rd_l;
                        found_reg[1]  <= 1'b1;
                    end
                    prev_s_reg <= rd_s;
                    prev_l_reg <= rd_l;
                    k_reg      <= k_inc;
                    if (k_reg == last_idx)
                    begin
                        priority if (seg_reg[0])
                        begin
                            sel_reg   <= 1'b0;
                            state_reg <= ST_SUB;
                        end
                        else if (seg_reg[1])
                        begin
                            sel_reg   <= 1'b1;
                            state_reg <= ST_SUB;
                        end
                        else
                        begin
                            state_reg <= ST_TIGHT_LO;
                        end
                    end
                end

                ST_SUB:
                begin
                    if (cur_s1 <= cur_s0)
                    begin
                        val_reg[sel_reg] <= cur_l0;
                        if (!sel_reg && seg_reg[1])
                        begin
                            sel_reg   <= 1'b1;
                            state_reg <= ST_SUB;
                        end
                        else
                        begin
                            state_reg <= ST_TIGHT_LO;
                        end
                    end
                    else
                    begin
                        neg_reg   <= d_up[COORD_W];
                        mag_reg   <= d_up[COORD_W] ? d_dn[COORD_W-1:0] : d_up[COORD_W-1:0];
                        ds_reg    <= d_ds[COORD_W-1:0];
                        dsd_reg   <= d_dsd[COORD_W-1:0];
                        state_reg <= ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    prod_reg  <= PROD_W'(mag_reg) * PROD_W'(ds_reg);
                    state_reg <= ST_DIV_GO;
                end

                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV_WAIT;
                end

                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_ADD;
                    end
                end

                ST_ADD:
                begin
                    val_reg[sel_reg] <= interp_val;
                    if (!sel_reg && seg_reg[1])
                    begin
                        sel_reg   <= 1'b1;
                        state_reg <= ST_SUB;
                    end
                    else
                    begin
                        state_reg <= ST_TIGHT_LO;
                    end
                end

                ST_TIGHT_LO:
                begin
                    acc_reg   <= acc_any_reg ? pick(acc_reg, val_reg[0], forbid_left_reg)
                                             : val_reg[0];
                    state_reg <= ST_TIGHT_HI;
                end

                ST_TIGHT_HI:
                begin
                    acc_reg   <= pick(acc_reg, val_reg[1], forbid_left_reg);
                    state_reg <= ST_VIOL;
                end

                ST_VIOL:
                begin
                    res_applies_reg  <= 1'b1;
                    res_violates_reg <= forbid_left_reg ? (bl_hi_reg > acc_reg)
                                                        : (bl_lo_reg < acc_reg);
                    res_ext_reg      <= acc_reg;
                    state_reg        <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{(M_TDATA_W - COORD_W - 3){1'b0}}, res_status_reg,
                                         res_ext_reg, res_violates_reg, res_applies_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/pbc_vertex_mem.sv =====
// vertex store: one write port, one registered read port, (s,l) per entry
module pbc_vertex_mem
    import pbc_pkg::*;
#(
    parameter int DEPTH = MAX_VERTICES_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [COORD_W-1:0]  wdata_s,
    input  logic [COORD_W-1:0]  wdata_l,
    input  logic [AW-1:0]       raddr,
    output logic [COORD_W-1:0]  rdata_s,
    output logic [COORD_W-1:0]  rdata_l
);

    logic [2*COORD_W-1:0] mem [DEPTH];
    logic [2*COORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wdata_l, wdata_s};
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata_s = rdata_reg[COORD_W-1:0];
    assign rdata_l = rdata_reg[2*COORD_W-1:COORD_W];

endmodule

// ===== rtl/pbc_serial_div.sv =====
// restoring divider, one quotient bit per cycle, quotient known to fit COORD_W bits
module pbc_serial_div
    import pbc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROD_W-1:0]   dividend,
    input  logic [COORD_W-1:0]  divisor,
    output logic                done,
    output logic [COORD_W-1:0]  quotient
);

    localparam int SW = $clog2(DIV_STEPS);

    logic               busy_reg;
    logic               done_reg;
    logic [SW-1:0]      step_reg;
    logic [COORD_W-1:0] rem_reg;
    logic [COORD_W-1:0] quo_reg;
    logic [COORD_W:0]   trial;
    logic [COORD_W:0]   diff;
    logic               fits;

    assign trial = {rem_reg, quo_reg[COORD_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // high half is below the divisor, so only low bits remain to shift in
                rem_reg  <= dividend[PROD_W-1:COORD_W];
                quo_reg  <= dividend[COORD_W-1:0];
                step_reg <= SW'(DIV_STEPS - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
                quo_reg <= {quo_reg[COORD_W-2:0], fits};
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sim/testbench.sv =====
// testbench for the polyline lateral bound check unit: scoreboard prediction, directed and random stimulus
module testbench;
    import pbc_pkg::*;

    localparam int STORE_DEPTH    = MAX_VERTICES_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 200;
    localparam logic [31:0] MIN32 = 32'h8000_0000;
    localparam logic [31:0] MAX32 = 32'h7fff_ffff;

    typedef struct {
        logic        applies;
        logic        violates;
        logic [31:0] bound_l;
        logic        status;
    } verdict_t;

    class lateral_bound_tracker;
        longint      vertex_s[STORE_DEPTH];
        longint      vertex_l[STORE_DEPTH];
        int unsigned vertex_count;
        bit          forbid_left;
        verdict_t    pending_verdicts[$];
        int          mismatches;

        function new();
            vertex_count = 0;
            forbid_left  = 1'b1;
            mismatches   = 0;
        endfunction

        function longint tighter(longint a, longint b);
            if (forbid_left)
                return (a < b) ? a : b;
            return (a > b) ? a : b;
        endfunction

        function longint segment_l(longint s0, longint l0, longint s1, longint l1, longint s);
            longint dl;
            longint unsigned mag;
            longint unsigned q;
            if (s1 <= s0)
                return l0;
            dl  = l1 - l0;
            mag = (dl < 0) ? longint'(-dl) : dl;
            q   = (mag * longint'(s - s0)) / longint'(s1 - s0);
            return (dl < 0) ? l0 - longint'(q) : l0 + longint'(q);
        endfunction

        function longint boundary_l(longint s);
            int unsigned n;
            n = vertex_count;
            if (s <= vertex_s[0])
                return vertex_l[0];
            if (s >= vertex_s[n-1])
                return vertex_l[n-1];
            for (int unsigned k = 0; k + 1 < n; k++)
            begin
                if (s <= vertex_s[k+1])
                    return segment_l(vertex_s[k], vertex_l[k], vertex_s[k+1], vertex_l[k+1], s);
            end
            return vertex_l[n-1];
        endfunction

        function void take_request(action_t act, logic [S_TDATA_W-1:0] d);
            verdict_t v;
            longint   bs_lo, bs_hi, bl_lo, bl_hi, first_s, last_s, s_lo, s_hi, value;
            v = '{1'b0, 1'b0, 32'd0, 1'b0};
            case (act)
                ACT_CLEAR:
                    vertex_count = 0;
                ACT_APPEND:
                begin
                    if (vertex_count < STORE_DEPTH)
                    begin
                        vertex_s[vertex_count] = longint'($signed(d[31:0]));
                        vertex_l[vertex_count] = longint'($signed(d[63:32]));
                        vertex_count++;
                    end
                    else
                        v.status = 1'b1;
                end
                ACT_QUERY:
                begin
                    if (vertex_count >= 2)
                    begin
                        bs_lo   = longint'($signed(d[95:64]));
                        bs_hi   = longint'($signed(d[127:96]));
                        bl_lo   = longint'($signed(d[159:128]));
                        bl_hi   = longint'($signed(d[191:160]));
                        first_s = vertex_s[0];
                        last_s  = vertex_s[vertex_count-1];
                        if (!(bs_hi < first_s || bs_lo > last_s))
                        begin
                            s_lo  = (bs_lo > first_s) ? bs_lo : first_s;
                            s_hi  = (bs_hi < last_s) ? bs_hi : last_s;
                            value = tighter(boundary_l(s_lo), boundary_l(s_hi));
                            for (int unsigned k = 0; k < vertex_count; k++)
                            begin
                                if (vertex_s[k] > s_lo && vertex_s[k] < s_hi)
                                    value = tighter(value, vertex_l[k]);
                            end
                            v.applies  = 1'b1;
                            v.violates = forbid_left ? (bl_hi > value) : (bl_lo < value);
                            v.bound_l  = value[31:0];
                        end
                    end
                end
                default:
                    ;
            endcase
            pending_verdicts.insert(pending_verdicts.size(), v);
        endfunction

        function void match_verdict(logic [M_TDATA_W-1:0] d);
            verdict_t v;
            if (pending_verdicts.size() == 0)
            begin
                $error("result with no transaction pending: %h", d);
                mismatches++;
                return;
            end
            v = pending_verdicts.pop_front();
            if (d[0] !== v.applies)
            begin
                $error("applies expected %0d got %0d", v.applies, d[0]);
                mismatches++;
            end
            if (d[1] !== v.violates)
            begin
                $error("violates expected %0d got %0d", v.violates, d[1]);
                mismatches++;
            end
            if (d[33:2] !== v.bound_l)
            begin
                $error("bound_l expected %0d got %0d", $signed(v.bound_l), $signed(d[33:2]));
                mismatches++;
            end
            if (d[34] !== v.status)
            begin
                $error("status expected %0d got %0d", v.status, d[34]);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    lateral_bound_tracker board = new();

    int     send_idle_pct;
    int     recv_stall_pct;
    int     items_sent;
    int     quiet_cycles;
    longint poly_s[$];
    longint poly_l[$];

    polyline_lateral_bound_check_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.match_verdict(m_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [31:0] clamp32(longint x);
        if (x > 64'sd2147483647)
            return MAX32;
        if (x < -64'sd2147483648)
            return MIN32;
        return x[31:0];
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_box(logic [31:0] vs, logic [31:0] vl,
                                                      logic [31:0] s_lo, logic [31:0] s_hi,
                                                      logic [31:0] l_lo, logic [31:0] l_hi);
        return {l_hi, l_lo, s_hi, s_lo, vl, vs};
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_bits();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_item(action_t act, logic [S_TDATA_W-1:0] d);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        board.take_request(act, d);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (board.pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_side(bit left);
        cfg_we    <= 1'b1;
        cfg_wdata <= left;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.forbid_left = left;
    endtask

    function automatic longint pick_box_s();
        longint          first_s, last_s, span;
        longint unsigned r;
        first_s = (poly_s.size() != 0) ? poly_s[0] : 0;
        last_s  = (poly_s.size() != 0) ? poly_s[poly_s.size()-1] : 0;
        span    = last_s - first_s;
        r       = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return first_s - $urandom_range(0, 500);
            1: return last_s + $urandom_range(0, 500);
            2: return longint'($signed($urandom));
            3: return (poly_s.size() != 0) ? poly_s[$urandom_range(0, poly_s.size()-1)] : 0;
            default: return (span <= 0) ? first_s : first_s + longint'(r % (span + 1));
        endcase
    endfunction

    task automatic run_polyline_sequence();
        int     n, queries;
        bit     wide;
        longint s, l, center, lo, hi, tmp;
        poly_s.delete();
        poly_l.delete();
        wide = ($urandom_range(0, 3) == 0);
        n    = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
        push_item(ACT_CLEAR, random_bits());
        s = wide ? longint'($signed($urandom)) : longint'($urandom_range(0, 20000)) - 10000;
        for (int k = 0; k < n; k++)
        begin
            l = wide ? longint'($signed($urandom)) : longint'($urandom_range(0, 40000)) - 20000;
            if (poly_s.size() < STORE_DEPTH)
            begin
                poly_s.insert(poly_s.size(), longint'($signed(clamp32(s))));
                poly_l.insert(poly_l.size(), l);
            end
            push_item(ACT_APPEND, pack_box(clamp32(s), clamp32(l), $urandom, $urandom,
                                           $urandom, $urandom));
            if ($urandom_range(0, 9) != 0)
                s += wide ? longint'($urandom_range(0, 32'h1000_0000))
                          : longint'($urandom_range(1, 3000));
        end
        queries = $urandom_range(1, 6);
        for (int q = 0; q < queries; q++)
        begin
            lo = pick_box_s();
            hi = pick_box_s();
            if (lo > hi && $urandom_range(0, 4) != 0)
            begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            center = (poly_l.size() != 0) ? poly_l[$urandom_range(0, poly_l.size()-1)] : 0;
            if ($urandom_range(0, 4) == 0)
                push_item(ACT_QUERY, pack_box($urandom, $urandom, clamp32(lo), clamp32(hi),
                                              $urandom, $urandom));
            else
                push_item(ACT_QUERY, pack_box($urandom, $urandom, clamp32(lo), clamp32(hi),
                                              clamp32(center - $urandom_range(0, 2000)),
                                              clamp32(center + $urandom_range(0, 2000))));
        end
    endtask

    task automatic run_phase(int send_pct, int recv_pct, bit left, int budget);
        int target;
        drain();
        write_side(left);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target         = items_sent + budget;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 99) < 80)
                run_polyline_sequence();
            else
                push_item(action_t'($urandom_range(0, 3)), random_bits());
        end
    endtask

    task automatic run_directed();
        push_item(ACT_QUERY,  pack_box(0, 0, MIN32, MAX32, MIN32, MAX32));
        push_item(ACT_APPEND, pack_box(MIN32, MAX32, 0, 0, 0, 0));
        push_item(ACT_QUERY,  pack_box(0, 0, MIN32, MAX32, MIN32, MAX32));
        push_item(ACT_APPEND, pack_box(0, MIN32, 0, 0, 0, 0));
        // zero-length segment at s = 0
        push_item(ACT_APPEND, pack_box(0, 5000, 0, 0, 0, 0));
        push_item(ACT_APPEND, pack_box(MAX32, MAX32, 0, 0, 0, 0));
        push_item(ACT_QUERY,  pack_box(0, 0, MIN32, MAX32, MIN32, MAX32));
        push_item(ACT_QUERY,  pack_box(0, 0, -32'sd1000, 32'sd1000, -32'sd10, 32'sd10));
        push_item(ACT_QUERY,  pack_box(0, 0, 32'sd100, MAX32 - 1, 0, 0));
        push_item(ACT_QUERY,  pack_box(0, 0, 32'sd1000, -32'sd1000, MIN32, MIN32));
        push_item(ACT_NONE,   {S_TDATA_W{1'b1}});
        push_item(ACT_CLEAR,  '0);
        // backward segment in the middle
        push_item(ACT_APPEND, pack_box(32'sd100, 0, 0, 0, 0, 0));
        push_item(ACT_APPEND, pack_box(32'sd50, 32'sd700, 0, 0, 0, 0));
        push_item(ACT_APPEND, pack_box(32'sd300, -32'sd300, 0, 0, 0, 0));
        push_item(ACT_QUERY,  pack_box(0, 0, 0, 32'sd400, -32'sd500, 32'sd500));
        push_item(ACT_QUERY,  pack_box(0, 0, 32'sd400, 32'sd500, -32'sd500, 32'sd500));
        push_item(ACT_QUERY,  pack_box(0, 0, -32'sd10, 32'sd10, -32'sd500, 32'sd500));
        push_item(ACT_QUERY,  pack_box(0, 0, 32'sd250, 32'sd60, -32'sd500, 32'sd500));
        push_item(ACT_QUERY,  pack_box(0, 0, 32'sd75, 32'sd75, 0, 0));
        push_item(ACT_CLEAR,  '0);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ACT_CLEAR;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        quiet_cycles   = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        write_side(1'b1);
        run_directed();
        run_phase(0, 0, 1'b0, 400);
        run_phase(61, 0, 1'b1, 420);
        run_phase(0, 61, 1'b0, 420);
        run_phase(30, 30, 1'b1, 420);
        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.mismatches == 0 && board.pending_verdicts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
